### src/serial_tagged_packet_fifo_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial tagged packet FIFO
// Concurrent checks that are sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_TAGGED_PACKET_FIFO_ASSERT_SVH
`define SERIAL_TAGGED_PACKET_FIFO_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define STPF_ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STPF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/stpf_pkg.sv
// ----------------------------------------------------------------------------
// Serial tagged packet FIFO package
// Request and status codes, the stored entry layout and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package stpf_pkg;

	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;
	localparam int SIZE_W   = 24;
	localparam int DUR_W    = 32;
	localparam int DTS_W    = 48;
	localparam int STREAM_W = 8;
	localparam int SERIAL_W = 16;
	localparam int QCOUNT_W = 7;
	localparam int BYTES_W  = 31;
	localparam int DTOT_W   = 38;
	localparam int SPAN_W   = 49;

	localparam logic [REQ_W-1:0] REQ_PUT     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_GET     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_START   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_ABORT   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ABORTED = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

	// The smallest timestamp value stands for an absent timestamp.
	localparam logic [DTS_W-1:0] DTS_NONE = {1'b1, {(DTS_W-1){1'b0}}};

	typedef struct packed {
		logic                is_flush;
		logic [SERIAL_W-1:0] serial;
		logic [STREAM_W-1:0] stream;
		logic [DTS_W-1:0]    dts;
		logic [DUR_W-1:0]    duration;
		logic [SIZE_W-1:0]   size;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SPAN
	} state_t;

endpackage

`default_nettype wire

### src/serial_tagged_packet_fifo.sv
// ----------------------------------------------------------------------------
// Serial tagged packet FIFO
// Packet descriptor queue with generation serials and occupancy totals.
// ----------------------------------------------------------------------------
// Each request goes through ST_IDLE, which accepts it and reads the head
// entry, ST_EXEC, which carries out the operation and reads the new head,
// and ST_SPAN, which forms the timestamp span and loads the result register.
// The descriptor memory has a single registered read port. A new request is
// taken while an earlier result still waits in the output register; only the
// loading of the next result waits for it.
`default_nettype none

module serial_tagged_packet_fifo import stpf_pkg::*; #(
	parameter int DEPTH          = 64,
	parameter int ENTRY_OVERHEAD = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pkt_size, pkt_duration, pkt_dts, pkt_stream
	input  wire logic [111:0] s_tdata,
	// req_type, mark_flush
	input  wire logic [3:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_size, out_duration, out_dts, out_stream, out_serial, queued_count,
	// total_bytes, total_duration, dts_span, span_valid, two zero bits
	output logic [255:0]      m_tdata,
	// status, out_is_flush
	output logic [2:0]        m_tuser
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0]      LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0]      FULL_CNT = CW'(DEPTH);
	localparam logic [BYTES_W-1:0] OVH      = BYTES_W'(ENTRY_OVERHEAD);

	state_t state_q, state_d;
	logic   exec_en, load_out;

	// Request captured on acceptance.
	logic [REQ_W-1:0]    req_q;
	logic                flush_q;
	logic [SIZE_W-1:0]   size_q;
	logic [DUR_W-1:0]    dur_q;
	logic [DTS_W-1:0]    dts_q;
	logic [STREAM_W-1:0] stream_q;

	// Queue control and totals.
	logic [PW-1:0]       head_q, head_d, tail_q, tail_d;
	logic [CW-1:0]       count_q, count_d;
	logic [BYTES_W-1:0]  bytes_q, bytes_d;
	logic [DTOT_W-1:0]   dtot_q, dtot_d;
	logic [SERIAL_W-1:0] gen_q, gen_d;
	logic                aborted_q, aborted_d;
	logic [DTS_W-1:0]    tail_dts_q;

	entry_t mem [DEPTH];
	entry_t rdata_q;
	entry_t wr_entry;
	logic   do_put, put_flush, do_get, do_clear;

	// Result of the operation, held until the span is known.
	logic [STATUS_W-1:0] status_d, res_status_q;
	entry_t              res_entry_q;

	logic                span_ok;
	logic [SPAN_W-1:0]   span;
	logic [31:0]         count_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_SPAN;
			end
			ST_SPAN: begin
				if (!m_tvalid || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		exec_en  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EXEC: exec_en  = 1'b1;
			ST_SPAN: load_out = !m_tvalid || m_tready;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q    <= s_tuser[2:0];
			flush_q  <= s_tuser[3];
			size_q   <= s_tdata[23:0];
			dur_q    <= s_tdata[55:24];
			dts_q    <= s_tdata[103:56];
			stream_q <= s_tdata[111:104];
		end
	end

	// Operation decode, evaluated only in the execute cycle.
	always_comb begin
		do_put    = 1'b0;
		put_flush = 1'b0;
		do_get    = 1'b0;
		do_clear  = 1'b0;
		aborted_d = aborted_q;
		status_d  = STAT_OK;
		if (exec_en) begin
			unique case (req_q)
				REQ_PUT: begin
					if (aborted_q) begin
						status_d = STAT_ABORTED;
					end else if (count_q == FULL_CNT) begin
						status_d = STAT_FULL;
					end else begin
						do_put    = 1'b1;
						put_flush = flush_q;
					end
				end
				REQ_GET: begin
					if (aborted_q) begin
						status_d = STAT_ABORTED;
					end else if (count_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						do_get = 1'b1;
					end
				end
				REQ_FLUSH: begin
					do_clear = 1'b1;
				end
				REQ_START: begin
					aborted_d = 1'b0;
					if (count_q == FULL_CNT) begin
						status_d = STAT_FULL;
					end else begin
						do_put    = 1'b1;
						put_flush = 1'b1;
					end
				end
				REQ_ABORT: begin
					aborted_d = 1'b1;
				end
				REQ_DESTROY: begin
					do_clear  = 1'b1;
					aborted_d = 1'b1;
				end
				default: begin
					status_d = STAT_OK;
				end
			endcase
		end
	end

	always_comb begin
		gen_d = put_flush ? gen_q + 1'b1 : gen_q;
		if (put_flush) begin
			wr_entry          = '0;
			wr_entry.is_flush = 1'b1;
			wr_entry.serial   = gen_d;
		end else begin
			wr_entry.is_flush = 1'b0;
			wr_entry.serial   = gen_q;
			wr_entry.stream   = stream_q;
			wr_entry.dts      = dts_q;
			wr_entry.duration = dur_q;
			wr_entry.size     = size_q;
		end
	end

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		bytes_d = bytes_q;
		dtot_d  = dtot_q;
		priority if (do_clear) begin
			head_d  = '0;
			tail_d  = '0;
			count_d = '0;
			bytes_d = '0;
			dtot_d  = '0;
		end else if (do_put) begin
			tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
			count_d = count_q + 1'b1;
			bytes_d = bytes_q + BYTES_W'(wr_entry.size) + OVH;
			dtot_d  = dtot_q + DTOT_W'(wr_entry.duration);
		end else if (do_get) begin
			head_d  = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
			count_d = count_q - 1'b1;
			bytes_d = bytes_q - BYTES_W'(rdata_q.size) - OVH;
			dtot_d  = dtot_q - DTOT_W'(rdata_q.duration);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			bytes_q   <= '0;
			dtot_q    <= '0;
			gen_q     <= '0;
			aborted_q <= 1'b1;
		end else begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			bytes_q   <= bytes_d;
			dtot_q    <= dtot_d;
			gen_q     <= do_put ? gen_d : gen_q;
			aborted_q <= aborted_d;
		end
	end

	// The read always follows the next head, so rdata_q holds the entry at
	// head_q from the same clock edge that loads the new head pointer.
	always_ff @(posedge clk) begin
		if (do_put) begin
			mem[tail_q] <= wr_entry;
			tail_dts_q  <= wr_entry.dts;
		end
		rdata_q <= mem[head_d];
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			res_status_q <= status_d;
			res_entry_q  <= do_get ? rdata_q : '0;
		end
	end

	always_comb begin
		span_ok = (count_q >= CW'(2)) && (rdata_q.dts != DTS_NONE)
			&& (tail_dts_q != DTS_NONE);
		span = span_ok ? {tail_dts_q[DTS_W-1], tail_dts_q}
			- {rdata_q.dts[DTS_W-1], rdata_q.dts} : '0;
		count_wide = 32'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {2'b00, span_ok, span, dtot_q, bytes_q,
				count_wide[QCOUNT_W-1:0], res_entry_q.serial, res_entry_q.stream,
				res_entry_q.dts, res_entry_q.duration, res_entry_q.size};
			m_tuser <= {res_entry_q.is_flush, res_status_q};
		end
	end

`include "serial_tagged_packet_fifo_assert.svh"

	`STPF_ASSERT_ALWAYS(a_count_bound, count_q <= FULL_CNT, "entry count exceeds depth")
	`STPF_ASSERT_ALWAYS(a_ptr_match,
		(count_q != '0 && count_q != FULL_CNT) || head_q == tail_q,
		"pointers disagree with count")
	`STPF_ASSERT_NEXT(a_exec_to_span, state_q == ST_EXEC, state_q == ST_SPAN,
		"execute cycle not followed by span cycle")
	`STPF_ASSERT_NEXT(a_load_valid, load_out, m_tvalid, "result loaded but not presented")

endmodule

`default_nettype wire

### tb/tb_serial_tagged_packet_fifo.sv
// ----------------------------------------------------------------------------
// Testbench for the serial tagged packet FIFO
// Requests are sent over the slave stream and every result on the master
// stream is checked field by field. The expected values come from a
// behavioural model of the descriptor queue kept in this file. Both stream
// sides idle at random, the result side holds off once for a long stretch,
// and the store is filled past full several times.
// ----------------------------------------------------------------------------

module tb_serial_tagged_packet_fifo import stpf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIFO_DEPTH     = 64;
	localparam int FIFO_OVERHEAD  = 64;
	localparam int CYCLE_LIMIT    = 200000;

	// Request codes that the block treats as no operation.
	localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

	localparam logic [DTS_W-1:0] DTS_MAX = {1'b0, {(DTS_W-1){1'b1}}};

	typedef struct {
		logic [REQ_W-1:0]    kind;
		logic                marker;
		logic [SIZE_W-1:0]   size;
		logic [DUR_W-1:0]    dur;
		logic [DTS_W-1:0]    dts;
		logic [STREAM_W-1:0] stream;
		bit                  after_drain;
	} fifo_req_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SIZE_W-1:0]   size;
		logic [DUR_W-1:0]    dur;
		logic [DTS_W-1:0]    dts;
		logic [STREAM_W-1:0] stream;
		logic                is_flush;
		logic [SERIAL_W-1:0] serial;
		logic [QCOUNT_W-1:0] count;
		logic [BYTES_W-1:0]  bytes;
		logic [DTOT_W-1:0]   dtot;
		logic [SPAN_W-1:0]   span;
		logic                span_ok;
	} fifo_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [3:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [255:0] m_tdata;
	logic [2:0]   m_tuser;

	serial_tagged_packet_fifo #(
		.DEPTH(FIFO_DEPTH),
		.ENTRY_OVERHEAD(FIFO_OVERHEAD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	fifo_req_t    req_plan[$];
	fifo_result_t pending_results[$];
	fifo_req_t    in_flight;

	// Model of the queue contents and its running totals.
	entry_t              model_entries[$];
	logic [BYTES_W-1:0]  model_bytes;
	logic [DTOT_W-1:0]   model_dur;
	logic [SERIAL_W-1:0] model_gen;
	logic                model_aborted;

	int errors = 0;
	int reqs_accepted = 0;
	int results_seen = 0;
	int status_hits[4] = '{0, 0, 0, 0};
	int markers_out = 0;
	int peak_fill = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic fifo_req_t mk_req(logic [REQ_W-1:0] kind, logic marker,
			logic [SIZE_W-1:0] size, logic [DUR_W-1:0] dur, logic [DTS_W-1:0] dts,
			logic [STREAM_W-1:0] stream, bit after_drain = 1'b0);
		fifo_req_t r;
		r.kind = kind;
		r.marker = marker;
		r.size = size;
		r.dur = dur;
		r.dts = dts;
		r.stream = stream;
		r.after_drain = after_drain;
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] rnd_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SIZE_W'($urandom());
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] rnd_dur();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DTS_W-1:0] rnd_dts();
		case ($urandom_range(0, 9))
			0: return DTS_NONE;
			1: return '0;
			2: return DTS_MAX;
			3: return DTS_NONE + 1'b1;
			default: return DTS_W'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic fifo_req_t rnd_req(logic [REQ_W-1:0] kind, logic marker);
		return mk_req(kind, marker, rnd_size(), rnd_dur(), rnd_dts(),
			STREAM_W'($urandom_range(0, 255)));
	endfunction

	function automatic logic [STATUS_W-1:0] model_enqueue(logic marker,
			fifo_req_t r);
		entry_t e;
		if (model_aborted)
			return STAT_ABORTED;
		if (model_entries.size() >= FIFO_DEPTH)
			return STAT_FULL;
		if (marker) begin
			model_gen = model_gen + 1'b1;
			e.size = '0;
			e.duration = '0;
			e.dts = '0;
			e.stream = '0;
		end else begin
			e.size = r.size;
			e.duration = r.dur;
			e.dts = r.dts;
			e.stream = r.stream;
		end
		e.is_flush = marker;
		e.serial = model_gen;
		model_entries.push_back(e);
		model_bytes = BYTES_W'(model_bytes + e.size + FIFO_OVERHEAD);
		model_dur = model_dur + e.duration;
		return STAT_OK;
	endfunction

	function automatic void model_clear();
		model_entries.delete();
		model_bytes = '0;
		model_dur = '0;
	endfunction

	// Applies one request to the queue model and forms the result it causes.
	function automatic void queue_model_step(input fifo_req_t r,
			output fifo_result_t res);
		entry_t head;
		entry_t tail;
		res = '{default: '0};
		case (r.kind)
			REQ_PUT: res.status = model_enqueue(r.marker, r);
			REQ_GET: begin
				if (model_aborted) begin
					res.status = STAT_ABORTED;
				end else if (model_entries.size() == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					head = model_entries[0];
					model_entries.delete(0);
					res.size = head.size;
					res.dur = head.duration;
					res.dts = head.dts;
					res.stream = head.stream;
					res.is_flush = head.is_flush;
					res.serial = head.serial;
					model_bytes = BYTES_W'(model_bytes - head.size - FIFO_OVERHEAD);
					model_dur = model_dur - head.duration;
				end
			end
			REQ_FLUSH: model_clear();
			REQ_START: begin
				model_aborted = 1'b0;
				res.status = model_enqueue(1'b1, r);
			end
			REQ_ABORT: model_aborted = 1'b1;
			REQ_DESTROY: begin
				model_clear();
				model_aborted = 1'b1;
			end
			default: ;
		endcase
		res.count = QCOUNT_W'(model_entries.size());
		res.bytes = model_bytes;
		res.dtot = model_dur;
		if (model_entries.size() >= 2) begin
			head = model_entries[0];
			tail = model_entries[$];
			if (head.dts != DTS_NONE && tail.dts != DTS_NONE) begin
				res.span = $signed({tail.dts[DTS_W-1], tail.dts})
					- $signed({head.dts[DTS_W-1], head.dts});
				res.span_ok = 1'b1;
			end
		end
	endfunction

	// A random mix of requests; an abort or a destroy is soon followed by a
	// start so that most of the traffic reaches an open queue.
	task automatic add_mixed(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				req_plan.push_back(rnd_req(REQ_PUT, $urandom_range(0, 9) == 0));
			end else if (pick < 85) begin
				req_plan.push_back(rnd_req(REQ_GET, 1'($urandom_range(0, 1))));
			end else if (pick < 88) begin
				req_plan.push_back(rnd_req(REQ_FLUSH, 1'($urandom_range(0, 1))));
			end else if (pick < 91) begin
				req_plan.push_back(rnd_req(REQ_START, 1'($urandom_range(0, 1))));
			end else if (pick < 97) begin
				req_plan.push_back(rnd_req(pick < 94 ? REQ_ABORT : REQ_DESTROY,
					1'($urandom_range(0, 1))));
				repeat ($urandom_range(0, 3))
					req_plan.push_back(rnd_req($urandom_range(0, 1) ? REQ_PUT : REQ_GET,
						1'($urandom_range(0, 1))));
				req_plan.push_back(rnd_req(REQ_START, 1'($urandom_range(0, 1))));
			end else begin
				req_plan.push_back(rnd_req($urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7,
					1'($urandom_range(0, 1))));
			end
		end
	endtask

	// Fills the store past full, tries a start and a marker while full,
	// then reads back more entries than it holds.
	task automatic add_fill_pass();
		req_plan.push_back(mk_req(REQ_START, 1'b0, '0, '0, '0, '0, 1'b1));
		repeat (FIFO_DEPTH + 6)
			req_plan.push_back(rnd_req(REQ_PUT, $urandom_range(0, 15) == 0));
		req_plan.push_back(rnd_req(REQ_START, 1'b1));
		req_plan.push_back(rnd_req(REQ_PUT, 1'b1));
		repeat (FIFO_DEPTH + 6)
			req_plan.push_back(rnd_req(REQ_GET, 1'($urandom_range(0, 1))));
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] seen);
		if (seen !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what,
				want, seen);
		end
	endtask

	task automatic check_result();
		fifo_result_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			errors++;
			$display("%0t: result with nothing outstanding, expected none, actual %h %h",
				$time, m_tuser, m_tdata);
			return;
		end
		want = pending_results[0];
		pending_results.delete(0);
		status_hits[want.status]++;
		if (want.is_flush)
			markers_out++;
		check_field("status", want.status, m_tuser[1:0]);
		check_field("out_is_flush", want.is_flush, m_tuser[2]);
		check_field("out_size", want.size, m_tdata[23:0]);
		check_field("out_duration", want.dur, m_tdata[55:24]);
		check_field("out_dts", want.dts, m_tdata[103:56]);
		check_field("out_stream", want.stream, m_tdata[111:104]);
		check_field("out_serial", want.serial, m_tdata[127:112]);
		check_field("queued_count", want.count, m_tdata[134:128]);
		check_field("total_bytes", want.bytes, m_tdata[165:135]);
		check_field("total_duration", want.dtot, m_tdata[203:166]);
		check_field("dts_span", want.span, m_tdata[252:204]);
		check_field("span_valid", want.span_ok, m_tdata[253]);
	endtask

	// Request side: one transfer at a time from the plan, with random gaps.
	always @(posedge clk) begin
		fifo_result_t res;
		bit go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				queue_model_step(in_flight, res);
				pending_results.push_back(res);
				reqs_accepted++;
				if (model_entries.size() > peak_fill)
					peak_fill = model_entries.size();
			end
			if (!s_tvalid || s_tready) begin
				go = req_plan.size() != 0;
				if (go && req_plan[0].after_drain && pending_results.size() != 0)
					go = 0;
				if (go && !(reqs_accepted >= 500 && reqs_accepted < 700)
						&& $urandom_range(0, 99) < 9)
					go = 0;
				if (go) begin
					in_flight = req_plan[0];
					req_plan.delete(0);
					s_tvalid <= 1'b1;
					s_tdata <= {in_flight.stream, in_flight.dts, in_flight.dur,
						in_flight.size};
					s_tuser <= {in_flight.marker, in_flight.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side: random back-pressure and one long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (results_seen >= 300 && !hold_done) begin
				hold_done = 1;
				hold_left = 200;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (results_seen >= 500 && results_seen < 700)
					|| $urandom_range(0, 99) >= 9;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d requests and %0d results outstanding",
				req_plan.size(), pending_results.size());
			$display("tb_serial_tagged_packet_fifo: done, errors");
			$finish;
		end
	end

	initial begin
		model_clear();
		model_gen = '0;
		model_aborted = 1'b1;

		// Directed opening: requests while aborted, the unused codes, field
		// extremes, absent timestamps and markers with stray payload fields.
		req_plan.push_back(rnd_req(REQ_GET, 1'b0));
		req_plan.push_back(mk_req(REQ_PUT, 1'b0, '1, '1, DTS_MAX, '1));
		req_plan.push_back(rnd_req(REQ_SPARE6, 1'b1));
		req_plan.push_back(rnd_req(REQ_SPARE7, 1'b0));
		req_plan.push_back(rnd_req(REQ_FLUSH, 1'b1));
		req_plan.push_back(rnd_req(REQ_START, 1'b0));
		req_plan.push_back(rnd_req(REQ_GET, 1'b0));
		req_plan.push_back(rnd_req(REQ_GET, 1'b0));
		req_plan.push_back(mk_req(REQ_PUT, 1'b0, '1, '1, DTS_MAX, '1, 1'b1));
		req_plan.push_back(mk_req(REQ_PUT, 1'b0, '0, '0, DTS_NONE, '0));
		req_plan.push_back(mk_req(REQ_PUT, 1'b0, 24'h5a5a5a, 32'ha5a5a5a5,
			DTS_NONE + 1'b1, 8'h5a));
		req_plan.push_back(mk_req(REQ_PUT, 1'b1, '1, '1, DTS_MAX, '1));
		req_plan.push_back(rnd_req(REQ_GET, 1'b0));
		req_plan.push_back(rnd_req(REQ_GET, 1'b1));
		req_plan.push_back(mk_req(REQ_ABORT, 1'b0, '0, '0, '0, '0, 1'b1));
		req_plan.push_back(rnd_req(REQ_PUT, 1'b0));
		req_plan.push_back(rnd_req(REQ_GET, 1'b0));
		req_plan.push_back(rnd_req(REQ_START, 1'b1));
		req_plan.push_back(rnd_req(REQ_DESTROY, 1'b0));
		req_plan.push_back(rnd_req(REQ_START, 1'b0));
		req_plan.push_back(rnd_req(REQ_PUT, 1'b0));
		req_plan.push_back(rnd_req(REQ_GET, 1'b0));
		req_plan.push_back(rnd_req(REQ_FLUSH, 1'b0));

		repeat (3) begin
			add_mixed(200);
			add_fill_pass();
		end
		add_mixed(150);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (req_plan.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("summary: %0d requests, %0d results, %0d markers read back, peak fill %0d",
			reqs_accepted, results_seen, markers_out, peak_fill);
		$display("summary: status ok %0d, empty %0d, aborted %0d, full %0d",
			status_hits[STAT_OK], status_hits[STAT_EMPTY], status_hits[STAT_ABORTED],
			status_hits[STAT_FULL]);
		if (errors == 0)
			$display("tb_serial_tagged_packet_fifo: done, clean");
		else
			$display("tb_serial_tagged_packet_fifo: done, errors");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/stpf_pkg.sv
src/serial_tagged_packet_fifo.sv
tb/tb_serial_tagged_packet_fifo.sv
